// File: rtl/core/trc_pkg.sv
// Shared types and constants of the throttle response curve.
package trc_pkg;

   localparam logic [14:0] ONE_Q14   = 15'd16384;
   localparam logic [14:0] ONE_Q11   = 15'd2048;
   localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

   localparam int LOG_STEPS   = 16;
   localparam int EXP_STEPS   = 16;
   localparam int ROOT_DIGITS = 31;
   localparam int EXP_STAGES  = EXP_STEPS * ROOT_DIGITS;
   localparam int DIV_BITS    = 15;

   localparam logic [1:0] REG_ACCEL_CURVE = 2'd0;
   localparam logic [1:0] REG_BRAKE_CURVE = 2'd1;
   localparam logic [1:0] REG_CURVE_MODE  = 2'd2;

   typedef enum logic [1:0] {
      MODE_POWER  = 2'd0,
      MODE_EXP    = 2'd1,
      MODE_POLY   = 2'd2,
      MODE_LINEAR = 2'd3
   } curve_mode_type;

   typedef struct packed {
      logic           neg;
      curve_mode_type mode;
      logic           cpos;
      logic           cneg;
      logic [14:0]    x;
      logic [14:0]    a;
      logic [14:0]    y;
      logic [14:0]    w;
      logic [28:0]    pden;
      logic [19:0]    nes;
      logic [19:0]    nea;
      logic [14:0]    res;
      logic           use_div;
      logic           div_sub;
   } ctl_type;

   typedef struct packed {
      logic [30:0] m;
      logic [15:0] frac;
      logic [3:0]  p;
   } log_lane_type;

   typedef struct packed {
      logic [30:0] root;
      logic [63:0] rem;
      logic [15:0] g;
      logic [7:0]  k;
      logic        spec;
      logic [30:0] specval;
   } exp_lane_type;

   typedef struct packed {
      logic [45:0] rem;
      logic [30:0] d;
      logic [14:0] q;
   } div_lane_type;

endpackage

// File: rtl/core/trc_if.sv
// Channel interfaces of the throttle response curve.
interface trc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] throttle_in;
   modport source (output valid, output throttle_in, input ready);
   modport sink (input valid, input throttle_in, output ready);
endinterface

interface trc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] throttle_out;
   modport source (output valid, output throttle_out, input ready);
   modport sink (input valid, input throttle_out, output ready);
endinterface

interface trc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/throttle_response_curve.sv
// Throttle response curve: a fully pipelined shaper for signed Q1.14 throttle samples.
//
// The block takes one throttle transaction on every cycle while the skid stage is
// empty, and returns one shaped transaction for each, in order. The latency is set
// mainly by the base-two exponential unit: sixteen
// floor square roots of a 62-bit radicand, each worked out one root digit per
// stage (496 stages, two such lanes side by side), ahead of that a sixteen-stage
// squaring logarithm and behind it a fifteen-stage restoring divider. A stall on
// the result side freezes the whole pipeline; an output register with a one-entry
// skid stage lets the block take a further transaction while a result waits.
// The configuration port is always ready; write the curve registers only while no
// transaction is in flight.
module throttle_response_curve import trc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   trc_req_if.sink      req_ch,
   trc_rsp_if.source    rsp_ch,
   trc_csr_if.sink      csr_ch
);

   // ---------------------------------------------------------------- helpers
   // One squaring step of the logarithm: square, renormalise, record the bit.
   function automatic log_lane_type log_step(input log_lane_type li, input int unsigned bitpos);
      log_lane_type lo;
      logic [61:0]  mm;
      logic [31:0]  sq;
      lo = li;
      mm = 62'(li.m) * 62'(li.m);
      sq = mm[61:30];
      if (sq[31]) begin
         lo.m = sq[31:1];
         lo.frac[bitpos[3:0]] = 1'b1;
      end else begin
         lo.m = sq[30:0];
      end
      return lo;
   endfunction

   // One root digit of one square-root step; the first digit also forms the radicand,
   // doubling the root first when the step's bit of g is set.
   function automatic exp_lane_type exp_digit(input exp_lane_type li, input int unsigned step,
                                              input int unsigned dig);
      exp_lane_type lo;
      logic [31:0]  r;
      logic [63:0]  rem0;
      logic [63:0]  t;
      logic [30:0]  root0;
      lo = li;
      if (dig == ROOT_DIGITS - 1) begin
         r = {1'b0, li.root};
         if (li.g[step[3:0]]) begin
            r = {li.root, 1'b0};
         end
         rem0  = {2'b00, r, 30'd0};
         root0 = '0;
      end else begin
         rem0  = li.rem;
         root0 = li.root;
      end
      t = (64'(root0) << (dig + 1)) + (64'd1 << (2 * dig));
      if (rem0 >= t) begin
         lo.rem  = rem0 - t;
         lo.root = root0 | (31'd1 << dig);
      end else begin
         lo.rem  = rem0;
         lo.root = root0;
      end
      return lo;
   endfunction

   // One quotient bit of the restoring divider.
   function automatic div_lane_type div_step(input div_lane_type li, input int unsigned bitpos);
      div_lane_type lo;
      logic [45:0]  t;
      lo = li;
      t  = 46'(li.d) << bitpos;
      if (li.rem >= t) begin
         lo.rem = li.rem - t;
         lo.q[bitpos[3:0]] = 1'b1;
      end
      return lo;
   endfunction

   // ---------------------------------------------------------------- registers
   logic signed [15:0] accel_ff;
   logic signed [15:0] brake_ff;
   curve_mode_type     mode_ff;

   logic               adv;

   logic               v1_ff;
   ctl_type            c1_ff;
   ctl_type            c1_in;
   logic               v2_ff;
   ctl_type            c2_ff;
   logic [28:0]        prod2_ff;
   logic               v3_ff;
   ctl_type            c3_ff;

   logic               vlog_ff [LOG_STEPS+1];
   ctl_type            clog_ff [LOG_STEPS+1];
   log_lane_type       log_ff  [LOG_STEPS+1];
   log_lane_type       log_in  [LOG_STEPS+1];

   logic               vn_ff;
   ctl_type            cn_ff;
   logic [23:0]        na_ff;
   logic [23:0]        nb_ff;

   logic               vexp_ff [EXP_STAGES+1];
   ctl_type            cexp_ff [EXP_STAGES+1];
   exp_lane_type       lana_ff [EXP_STAGES+1];
   exp_lane_type       lanb_ff [EXP_STAGES+1];
   exp_lane_type       lana_in [EXP_STAGES+1];
   exp_lane_type       lanb_in [EXP_STAGES+1];

   logic               vfin_ff;
   ctl_type            cfin_ff;
   logic [30:0]        exa_ff;
   logic [30:0]        exb_ff;

   logic               vdiv_ff [DIV_BITS+1];
   ctl_type            cdiv_ff [DIV_BITS+1];
   div_lane_type       div_ff  [DIV_BITS+1];
   div_lane_type       div_in  [DIV_BITS+1];
   ctl_type            cprep_in;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_data_ff;
   logic               skid_valid_ff;
   logic signed [15:0] skid_data_ff;
   logic signed [15:0] result_in;

   // ---------------------------------------------------------------- configuration
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= '0;
         brake_ff <= '0;
         mode_ff  <= MODE_LINEAR;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_ACCEL_CURVE: accel_ff <= csr_ch.data;
            REG_BRAKE_CURVE: brake_ff <= csr_ch.data;
            REG_CURVE_MODE:  mode_ff  <= curve_mode_type'(csr_ch.data[1:0]);
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   // The whole pipeline advances together unless the skid stage is occupied.
   assign adv          = !skid_valid_ff;
   assign req_ch.ready = adv;

   // ---------------------------------------------------------------- front end
   // Saturate the sample to +/-1.0, pick the curve by sign, saturate it to +/-8.0.
   always_comb begin
      logic signed [15:0] tsat;
      logic signed [15:0] craw;
      logic signed [15:0] csat;
      c1_in = '0;
      if (req_ch.throttle_in > 16'sd16384) begin
         tsat = 16'sd16384;
      end else if (req_ch.throttle_in < -16'sd16384) begin
         tsat = -16'sd16384;
      end else begin
         tsat = req_ch.throttle_in;
      end
      c1_in.neg = tsat[15];
      c1_in.x   = tsat[15] ? 15'(-tsat) : tsat[14:0];
      craw = tsat[15] ? brake_ff : accel_ff;
      if (craw > 16'sd16384) begin
         csat = 16'sd16384;
      end else if (craw < -16'sd16384) begin
         csat = -16'sd16384;
      end else begin
         csat = craw;
      end
      c1_in.cpos = (csat > 16'sd0);
      c1_in.cneg = csat[15];
      c1_in.a    = csat[15] ? 15'(-csat) : csat[14:0];
      c1_in.mode = mode_ff;
      // y: power base and polynomial numerator; w: ramp argument and polynomial term
      c1_in.y    = c1_in.cneg ? c1_in.x : ONE_Q14 - c1_in.x;
      c1_in.w    = c1_in.cneg ? ONE_Q14 - c1_in.x : c1_in.x;
   end

   // ---------------------------------------------------------------- logarithm lane
   always_comb begin
      logic [3:0] p;
      p = '0;
      for (int i = 0; i < 15; i++) begin
         if (c3_ff.y[i]) begin
            p = 4'(i);
         end
      end
      log_in[0].p    = p;
      log_in[0].frac = '0;
      log_in[0].m    = 31'(c3_ff.y) << (5'd30 - 5'(p));
   end

   for (genvar q = 1; q <= LOG_STEPS; q++) begin : g_log
      always_comb begin
         log_in[q] = log_step(log_ff[q-1], LOG_STEPS - q);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            log_ff[q]  <= log_in[q];
            clog_ff[q] <= clog_ff[q-1];
         end
      end
   end

   // ---------------------------------------------------------------- exponential lanes
   // Set up both lanes: split n into whole and fractional parts, catch the
   // shifts that leave nothing and the exact powers of two.
   always_comb begin
      logic [15:0] fa;
      logic [15:0] fb;
      fa = na_ff[15:0];
      fb = nb_ff[15:0];
      lana_in[0].root    = ONE_Q30;
      lana_in[0].rem     = '0;
      lana_in[0].k       = na_ff[23:16];
      lana_in[0].g       = 16'(17'h10000 - 17'(fa));
      lana_in[0].spec    = (fa == '0) || (na_ff[23:16] >= 8'd31);
      lana_in[0].specval = ((fa == '0) && (na_ff[23:16] < 8'd31)) ?
                           (ONE_Q30 >> na_ff[20:16]) : '0;
      lanb_in[0].root    = ONE_Q30;
      lanb_in[0].rem     = '0;
      lanb_in[0].k       = nb_ff[23:16];
      lanb_in[0].g       = 16'(17'h10000 - 17'(fb));
      lanb_in[0].spec    = (fb == '0) || (nb_ff[23:16] >= 8'd31);
      lanb_in[0].specval = ((fb == '0) && (nb_ff[23:16] < 8'd31)) ?
                           (ONE_Q30 >> nb_ff[20:16]) : '0;
   end

   for (genvar q = 1; q <= EXP_STAGES; q++) begin : g_exp
      localparam int unsigned STEP = (q - 1) / ROOT_DIGITS;
      localparam int unsigned DIG  = ROOT_DIGITS - 1 - ((q - 1) % ROOT_DIGITS);
      always_comb begin
         lana_in[q] = exp_digit(lana_ff[q-1], STEP, DIG);
         lanb_in[q] = exp_digit(lanb_ff[q-1], STEP, DIG);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            lana_ff[q] <= lana_in[q];
            lanb_ff[q] <= lanb_in[q];
            cexp_ff[q] <= cexp_ff[q-1];
         end
      end
   end

   // ---------------------------------------------------------------- operand preparation
   // Finish power and linear modes here; hand exponential and polynomial quotients to the divider.
   always_comb begin
      logic [31:0] pw_sum;
      logic [15:0] pw;
      logic [14:0] pwc;
      logic [30:0] den;
      logic [30:0] num;
      cprep_in = cfin_ff;
      pw_sum   = {1'b0, exa_ff} + 32'd32768;
      pw       = pw_sum[31:16];
      pwc      = (pw > 16'(ONE_Q14)) ? ONE_Q14 : pw[14:0];
      if (cfin_ff.y == '0) begin
         pwc = '0;
      end else if (cfin_ff.a == '0) begin
         pwc = cfin_ff.y;
      end
      den = (exb_ff < ONE_Q30) ? ONE_Q30 - exb_ff : '0;
      num = (exa_ff > exb_ff) ? exa_ff - exb_ff : '0;
      div_in[0].q   = '0;
      div_in[0].d   = 31'(cfin_ff.pden);
      div_in[0].rem = 46'({cfin_ff.y, 25'd0}) + 46'(cfin_ff.pden[28:1]);
      cprep_in.use_div = 1'b0;
      cprep_in.div_sub = 1'b0;
      cprep_in.res     = cfin_ff.x;
      case (cfin_ff.mode)
         MODE_POWER: begin
            cprep_in.res = cfin_ff.cneg ? pwc : ONE_Q14 - pwc;
         end
         MODE_EXP: begin
            div_in[0].d   = den;
            div_in[0].rem = 46'({num, 14'd0}) + 46'(den[30:1]);
            // zero curve and an empty denominator both fall back to linear
            if ((cfin_ff.cpos || cfin_ff.cneg) && (den != '0)) begin
               cprep_in.use_div = 1'b1;
               cprep_in.div_sub = cfin_ff.cpos;
            end
         end
         MODE_POLY: begin
            cprep_in.use_div = 1'b1;
            cprep_in.div_sub = !cfin_ff.cneg;
         end
         default: ;
      endcase
   end

   for (genvar q = 1; q <= DIV_BITS; q++) begin : g_div
      always_comb begin
         div_in[q] = div_step(div_ff[q-1], DIV_BITS - q);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[q]  <= div_in[q];
            cdiv_ff[q] <= cdiv_ff[q-1];
         end
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      logic [14:0] qc;
      logic [14:0] r;
      qc = (div_ff[DIV_BITS].q > ONE_Q14) ? ONE_Q14 : div_ff[DIV_BITS].q;
      if (cdiv_ff[DIV_BITS].use_div) begin
         r = cdiv_ff[DIV_BITS].div_sub ? ONE_Q14 - qc : qc;
      end else begin
         r = (cdiv_ff[DIV_BITS].res > ONE_Q14) ? ONE_Q14 : cdiv_ff[DIV_BITS].res;
      end
      result_in = cdiv_ff[DIV_BITS].neg ? 16'(16'd0 - 16'(r)) : 16'(r);
   end

   // ---------------------------------------------------------------- datapath registers
   always_ff @(posedge clock) begin
      logic [34:0] npow;
      logic [19:0] nlog;
      logic [59:0] nes;
      logic [59:0] nea;
      ctl_type     c2_in;
      ctl_type     c3_in;
      ctl_type     clog0_in;
      if (adv) begin
         // stage 1: capture the sanitised transaction
         c1_ff <= c1_in;
         // stage 2: a * w feeds both the ramp exponent and the polynomial denominator
         prod2_ff   <= 29'(30'(c1_ff.a) * 30'(c1_ff.w));
         c2_in      = c1_ff;
         c2_in.pden = 29'(30'(c1_ff.a) * 30'(c1_ff.w)) + 29'(1 << 25);
         c2_ff      <= c2_in;
         // stage 3: ramp exponent in base two
         nes        = 60'(prod2_ff) * 60'(LOG2E_Q30);
         c3_in      = c2_ff;
         c3_in.nes  = nes[58:39];
         c3_ff      <= c3_in;
         // stage 4: exponent at s = 1.0, start of the logarithm
         nea          = 60'({c3_ff.a, 14'd0}) * 60'(LOG2E_Q30);
         clog0_in     = c3_ff;
         clog0_in.nea = nea[58:39];
         clog_ff[0]   <= clog0_in;
         log_ff[0]    <= log_in[0];
         // exponent for power mode: -log2(base) * (1 + a)
         nlog  = {4'(4'd14 - log_ff[LOG_STEPS].p), 16'd0} - 20'(log_ff[LOG_STEPS].frac);
         npow  = 35'(nlog) * 35'(ONE_Q11 + clog_ff[LOG_STEPS].a);
         cn_ff <= clog_ff[LOG_STEPS];
         na_ff <= (clog_ff[LOG_STEPS].mode == MODE_POWER) ? npow[34:11]
                                                          : 24'(clog_ff[LOG_STEPS].nes);
         nb_ff <= 24'(clog_ff[LOG_STEPS].nea);
         // lane set-up
         lana_ff[0] <= lana_in[0];
         lanb_ff[0] <= lanb_in[0];
         cexp_ff[0] <= cn_ff;
         // scale the roots back down by 2^(k+1)
         cfin_ff <= cexp_ff[EXP_STAGES];
         exa_ff  <= lana_ff[EXP_STAGES].spec ? lana_ff[EXP_STAGES].specval :
                    lana_ff[EXP_STAGES].root >> (6'(lana_ff[EXP_STAGES].k[4:0]) + 6'd1);
         exb_ff  <= lanb_ff[EXP_STAGES].spec ? lanb_ff[EXP_STAGES].specval :
                    lanb_ff[EXP_STAGES].root >> (6'(lanb_ff[EXP_STAGES].k[4:0]) + 6'd1);
         // divider entry
         div_ff[0]  <= div_in[0];
         cdiv_ff[0] <= cprep_in;
      end
   end

   // ---------------------------------------------------------------- valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         vn_ff   <= 1'b0;
         vfin_ff <= 1'b0;
         for (int i = 0; i <= LOG_STEPS; i++) begin
            vlog_ff[i] <= 1'b0;
         end
         for (int i = 0; i <= EXP_STAGES; i++) begin
            vexp_ff[i] <= 1'b0;
         end
         for (int i = 0; i <= DIV_BITS; i++) begin
            vdiv_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff      <= req_ch.valid;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         vlog_ff[0] <= v3_ff;
         for (int i = 1; i <= LOG_STEPS; i++) begin
            vlog_ff[i] <= vlog_ff[i-1];
         end
         vn_ff      <= vlog_ff[LOG_STEPS];
         vexp_ff[0] <= vn_ff;
         for (int i = 1; i <= EXP_STAGES; i++) begin
            vexp_ff[i] <= vexp_ff[i-1];
         end
         vfin_ff    <= vexp_ff[EXP_STAGES];
         vdiv_ff[0] <= vfin_ff;
         for (int i = 1; i <= DIV_BITS; i++) begin
            vdiv_ff[i] <= vdiv_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------- output and skid
   // Hold a result in the skid stage when the output register is still waiting.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ch.ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_ch.ready) begin
         rsp_valid_ff <= vdiv_ff[DIV_BITS];
      end else if (vdiv_ff[DIV_BITS]) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ch.ready) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (!rsp_valid_ff || rsp_ch.ready) begin
         rsp_data_ff <= result_in;
      end else begin
         skid_data_ff <= result_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.throttle_out = rsp_data_ff;

   // ---------------------------------------------------------------- assertions
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid stage holds a result while the output register is empty");

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff <= 16'sd16384 && rsp_data_ff >= -16'sd16384))
      else $error("shaped throttle beyond plus or minus one");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !skid_valid_ff))
      else $error("result pending straight after reset");

endmodule
